@@ hw/rtl/integer_text_formatter_top_macros.svh @@
// Assertion macros used by the integer text formatter checker.
`ifndef INTEGER_TEXT_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_TOP_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define ITF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ITF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/itf_pkg.sv @@
// Shared types, codes and constants of the integer text formatter.
`default_nettype none

package itf_pkg;

    localparam int MAX_FIELD_DEF = 64;
    localparam int DIGIT_BUFFER  = 12;
    localparam int VALUE_W       = 32;
    localparam int DIG_W         = 4;
    localparam int LEN_W         = $clog2(DIGIT_BUFFER + 1);

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_LHEX = 3'd3;
    localparam logic [2:0] OP_UHEX = 3'd4;
    localparam logic [2:0] OP_PTR  = 3'd5;

    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_ZPAD  = 1;
    localparam int FLAG_PLUS  = 2;
    localparam int FLAG_SPACE = 3;
    localparam int FLAG_ALT   = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } t_base;

    typedef struct packed {
        logic start;
        logic pop;
    } t_dig_ctl;

    typedef struct packed {
        logic             ready;
        logic [LEN_W-1:0] len;
    } t_dig_stat;

endpackage

`default_nettype wire

@@ hw/rtl/itf_digits.sv @@
// Digit engine: bit-serial binary to decimal, direct octal or hex digits, leading-zero scan.
`default_nettype none

module itf_digits
    import itf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_dig_ctl                i_ctl,
    input  logic [VALUE_W-1:0]      i_mag,
    input  t_base                   i_base,
    input  logic                    i_extra,
    output t_dig_stat               o_stat,
    output logic [DIG_W-1:0]        o_digit
);

    localparam int DW    = DIG_W * DIGIT_BUFFER;
    localparam int OW    = 3 * DIGIT_BUFFER;
    localparam int BIT_W = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_READY
    } t_state;

    t_state             r_state, n_state;
    logic [DW-1:0]      r_dig, n_dig;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [LEN_W-1:0]   r_scan, n_scan;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_extra, n_extra;

    logic [OW-1:0]      oct_x;
    logic [DW-1:0]      oct_dig;
    logic [DW-1:0]      adj_dig;
    logic               top_zero;

    assign oct_x    = OW'(i_mag);
    assign top_zero = (r_dig[DW-1 -: DIG_W] == '0);

    always_comb begin
        for (int i = 0; i < DIGIT_BUFFER; i++) begin
            oct_dig[DIG_W*i +: DIG_W] = {1'b0, oct_x[3*i +: 3]};
            if (r_dig[DIG_W*i +: DIG_W] >= 4'd5) begin
                adj_dig[DIG_W*i +: DIG_W] = r_dig[DIG_W*i +: DIG_W] + 4'd3;
            end else begin
                adj_dig[DIG_W*i +: DIG_W] = r_dig[DIG_W*i +: DIG_W];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_mag   = r_mag;
        n_bit   = r_bit;
        n_scan  = r_scan;
        n_len   = r_len;
        n_extra = r_extra;
        if (i_ctl.start) begin
            n_mag   = i_mag;
            n_extra = i_extra;
            n_scan  = '0;
            n_bit   = '0;
            unique case (i_base)
                BASE_DEC: begin
                    n_dig   = '0;
                    n_state = S_CONV;
                end
                BASE_OCT: begin
                    n_dig   = oct_dig;
                    n_state = S_SCAN;
                end
                default: begin
                    n_dig   = DW'(i_mag);
                    n_state = S_SCAN;
                end
            endcase
        end else begin
            unique case (r_state)
                S_CONV: begin
                    n_dig = {adj_dig[DW-2:0], r_mag[VALUE_W-1]};
                    n_mag = {r_mag[VALUE_W-2:0], 1'b0};
                    n_bit = r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(VALUE_W - 1)) begin
                        n_state = S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!top_zero || r_scan == LEN_W'(DIGIT_BUFFER)) begin
                        n_len   = LEN_W'(DIGIT_BUFFER) - r_scan + LEN_W'(r_extra);
                        n_state = S_READY;
                        if (r_extra) begin
                            n_dig = r_dig >> DIG_W;
                        end
                    end else begin
                        n_dig  = r_dig << DIG_W;
                        n_scan = r_scan + LEN_W'(1);
                    end
                end
                S_READY: begin
                    if (i_ctl.pop) begin
                        n_dig = r_dig << DIG_W;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
            r_mag   <= n_mag;
            r_bit   <= n_bit;
            r_scan  <= n_scan;
            r_len   <= n_len;
            r_extra <= n_extra;
        end
    end

    assign o_stat.ready = (r_state == S_READY);
    assign o_stat.len   = r_len;
    assign o_digit      = r_dig[DW-1 -: DIG_W];

endmodule

`default_nettype wire

@@ hw/rtl/integer_text_formatter_top.sv @@
// Decimal runs the bit-serial conversion (octal and hex skip it), then the leading-zero scan.
// Then setup in S_WAIT, S_PLAN1 and S_PLAN2, then one character per cycle, strobe registered.
// A new transaction is accepted only when busy is low, after the previous one has chosen its
// last character; busy stays high through conversion, scan, setup and emit.
// Reset: synchronous active-low, clears both sequencers; busy low and no strobe after reset.
// The receiver cannot stall: characters leave one per cycle; busy holds off start.
`default_nettype none

module integer_text_formatter_top
    import itf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [2:0]          i_opcode,
    input  logic [4:0]          i_flag_bits,
    input  logic [6:0]          i_field_width,
    input  logic signed [6:0]   i_precision,
    output logic                o_strobe,
    output logic [7:0]          o_out_char,
    output logic                o_last,
    output logic [6:0]          o_total_count
);

    localparam int CW = $clog2(MAX_FIELD + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_PLAN1,
        S_PLAN2,
        S_EMIT
    } t_state;

    function automatic logic [7:0] f_ascii(input logic [3:0] d, input logic cap);
        logic [7:0] base;
        if (d < 4'd10) begin
            base = CH_ZERO;
        end else begin
            base = (cap ? CH_UA : CH_LA) - 8'd10;
        end
        return base + {4'h0, d};
    endfunction

    t_state            r_state, n_state;
    logic              r_left, n_left;
    logic              r_zpad, n_zpad;
    logic              r_cap, n_cap;
    logic [15:0]       r_pre, n_pre;
    logic [1:0]        r_plen, n_plen;
    logic [CW-1:0]     r_w, n_w;
    logic [CW-1:0]     r_prec, n_prec;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_c_lsp, n_c_lsp;
    logic [1:0]        r_c_pre, n_c_pre;
    logic [CW-1:0]     r_c_zp, n_c_zp;
    logic [CW-1:0]     r_c_pz, n_c_pz;
    logic [LEN_W-1:0]  r_c_dig, n_c_dig;
    logic [CW-1:0]     r_c_rsp, n_c_rsp;
    logic [CW-1:0]     r_remain, n_remain;
    logic [CW-1:0]     r_total, n_total;
    logic              r_strobe, n_strobe;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic [6:0]        r_count, n_count;

    logic              accept;
    logic              f_left, f_zpad, f_plus, f_space, f_alt;
    logic              a_signed, a_cap, a_hexpre, a_octpre, a_prec_on;
    t_base             a_base;
    logic [VALUE_W-1:0] a_mag;
    logic [XW-1:0]     w_x, p_x;
    logic [CW-1:0]     len_x, pad;
    logic              dig_sel;
    t_dig_ctl          dig_ctl;
    t_dig_stat         dig_stat;
    logic [DIG_W-1:0]  dig_top;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign f_left  = i_flag_bits[FLAG_LEFT];
    assign f_zpad  = i_flag_bits[FLAG_ZPAD];
    assign f_plus  = i_flag_bits[FLAG_PLUS];
    assign f_space = i_flag_bits[FLAG_SPACE];
    assign f_alt   = i_flag_bits[FLAG_ALT];
    assign w_x     = XW'(i_field_width);
    assign p_x     = XW'(i_precision[5:0]);
    assign a_prec_on = !i_precision[6];
    assign a_mag   = (a_signed && i_value[VALUE_W-1]) ? (VALUE_W'(0) - i_value) : i_value;
    assign len_x   = CW'(dig_stat.len);
    assign pad     = (r_w > r_n) ? (r_w - r_n) : '0;

    always_comb begin
        a_signed = 1'b0;
        a_cap    = 1'b0;
        a_hexpre = 1'b0;
        a_octpre = 1'b0;
        a_base   = BASE_DEC;
        unique case (i_opcode) inside
            OP_SDEC: begin
                a_signed = 1'b1;
            end
            OP_OCT: begin
                a_base   = BASE_OCT;
                a_octpre = f_alt;
            end
            OP_LHEX: begin
                a_base   = BASE_HEX;
                a_hexpre = f_alt;
            end
            OP_UHEX: begin
                a_base   = BASE_HEX;
                a_hexpre = f_alt;
                a_cap    = 1'b1;
            end
            OP_PTR: begin
                a_base   = BASE_HEX;
                a_hexpre = 1'b1;
            end
            OP_UDEC: begin
                a_base   = BASE_DEC;
            end
            default: begin
                a_base   = BASE_DEC;
            end
        endcase
    end

    assign dig_sel     = (r_state == S_EMIT) && (r_c_lsp == '0) && (r_c_pre == '0)
                         && (r_c_zp == '0) && (r_c_pz == '0) && (r_c_dig != '0);
    assign dig_ctl.start = accept;
    assign dig_ctl.pop   = dig_sel;

    itf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dig_ctl),
        .i_mag   (a_mag),
        .i_base  (a_base),
        .i_extra (a_octpre || (i_value == '0)),
        .o_stat  (dig_stat),
        .o_digit (dig_top)
    );

    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_zpad   = r_zpad;
        n_cap    = r_cap;
        n_pre    = r_pre;
        n_plen   = r_plen;
        n_w      = r_w;
        n_prec   = r_prec;
        n_n      = r_n;
        n_c_lsp  = r_c_lsp;
        n_c_pre  = r_c_pre;
        n_c_zp   = r_c_zp;
        n_c_pz   = r_c_pz;
        n_c_dig  = r_c_dig;
        n_c_rsp  = r_c_rsp;
        n_remain = r_remain;
        n_total  = r_total;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        n_count  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_left = f_left;
                    n_zpad = f_zpad && !f_left && !a_prec_on;
                    n_cap  = a_cap;
                    n_w    = (w_x > XW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(w_x);
                    if (!a_prec_on) begin
                        n_prec = '0;
                    end else if (p_x > XW'(MAX_FIELD - 2)) begin
                        n_prec = CW'(MAX_FIELD - 2);
                    end else begin
                        n_prec = CW'(p_x);
                    end
                    n_pre  = '0;
                    n_plen = '0;
                    if (a_signed && i_value[VALUE_W-1]) begin
                        n_pre  = {CH_MINUS, 8'h00};
                        n_plen = 2'd1;
                    end else if (a_signed && f_plus) begin
                        n_pre  = {CH_PLUS, 8'h00};
                        n_plen = 2'd1;
                    end else if (a_signed && f_space) begin
                        n_pre  = {CH_SPACE, 8'h00};
                        n_plen = 2'd1;
                    end else if (a_hexpre && i_value != '0) begin
                        n_pre  = {CH_ZERO, (a_cap ? CH_UX : CH_LX)};
                        n_plen = 2'd2;
                    end
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (dig_stat.ready) begin
                    n_state = S_PLAN1;
                end
            end
            S_PLAN1: begin
                n_n     = ((r_prec > len_x) ? r_prec : len_x) + CW'(r_plen);
                n_c_pz  = (r_prec > len_x) ? (r_prec - len_x) : '0;
                n_c_dig = dig_stat.len;
                n_state = S_PLAN2;
            end
            S_PLAN2: begin
                n_total  = (r_w > r_n) ? r_w : r_n;
                n_remain = (r_w > r_n) ? r_w : r_n;
                n_c_lsp  = (!r_left && !r_zpad) ? pad : '0;
                n_c_zp   = r_zpad ? pad : '0;
                n_c_rsp  = r_left ? pad : '0;
                n_c_pre  = r_plen;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                if (r_c_lsp != '0) begin
                    n_char  = CH_SPACE;
                    n_c_lsp = r_c_lsp - CW'(1);
                end else if (r_c_pre != '0) begin
                    n_char  = r_pre[15:8];
                    n_pre   = {r_pre[7:0], 8'h00};
                    n_c_pre = r_c_pre - 2'd1;
                end else if (r_c_zp != '0) begin
                    n_char  = CH_ZERO;
                    n_c_zp  = r_c_zp - CW'(1);
                end else if (r_c_pz != '0) begin
                    n_char  = CH_ZERO;
                    n_c_pz  = r_c_pz - CW'(1);
                end else if (r_c_dig != '0) begin
                    n_char  = f_ascii(dig_top, r_cap);
                    n_c_dig = r_c_dig - LEN_W'(1);
                end else begin
                    n_char  = CH_SPACE;
                    n_c_rsp = r_c_rsp - CW'(1);
                end
                n_remain = r_remain - CW'(1);
                if (r_remain == CW'(1)) begin
                    n_last  = 1'b1;
                    n_count = 7'(r_total);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
            r_count  <= n_count;
            r_left   <= n_left;
            r_zpad   <= n_zpad;
            r_cap    <= n_cap;
            r_pre    <= n_pre;
            r_plen   <= n_plen;
            r_w      <= n_w;
            r_prec   <= n_prec;
            r_n      <= n_n;
            r_c_lsp  <= n_c_lsp;
            r_c_pre  <= n_c_pre;
            r_c_zp   <= n_c_zp;
            r_c_pz   <= n_c_pz;
            r_c_dig  <= n_c_dig;
            r_c_rsp  <= n_c_rsp;
            r_remain <= n_remain;
            r_total  <= n_total;
            r_char   <= n_char;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_char    = r_char;
    assign o_last        = r_last;
    assign o_total_count = r_count;

endmodule

`default_nettype wire

@@ hw/rtl/itf_checker.sv @@
// Port-level checker for the integer text formatter and its bind.
`default_nettype none

`include "integer_text_formatter_top_macros.svh"

module itf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic       o_last,
    input wire logic [6:0] o_total_count
);

    `ITF_ASSERT_SAME(a_last_has_strobe, o_last, o_strobe, "last without strobe")
    `ITF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after transaction start")
    `ITF_ASSERT_NEXT(a_run_unbroken, o_strobe && !o_last, o_strobe, "gap inside a character run")
    `ITF_ASSERT_SAME(a_count_on_last, o_strobe && |o_total_count, o_last, "count before last")

endmodule

bind integer_text_formatter_top itf_checker u_itf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_last        (o_last),
    .o_total_count (o_total_count)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the integer text formatter: directed and random conversions checked per character.
module tb_top;
    import itf_pkg::*;

    localparam int TB_MAX_FIELD = MAX_FIELD_DEF;
    localparam int RANDOM_ITEMS = 305;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  opcode;
        logic [4:0]  flags;
        logic [6:0]  width;
        logic [6:0]  prec;
        logic [7:0]  gap;
        logic        drain;
    } t_fmt_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [6:0] count;
    } t_fmt_char;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic [31:0]        i_value       = '0;
    logic [2:0]         i_opcode      = '0;
    logic [4:0]         i_flag_bits   = '0;
    logic [6:0]         i_field_width = '0;
    logic signed [6:0]  i_precision   = '0;
    logic               o_strobe;
    logic [7:0]         o_out_char;
    logic               o_last;
    logic [6:0]         o_total_count;

    t_fmt_req  format_reqs[$];
    t_fmt_char field_chars[$];
    t_fmt_req  cur_req;
    int        idle_cycles    = 0;
    int        accepted_count = 0;
    int        chars_checked  = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    integer_text_formatter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_opcode      (i_opcode),
        .i_flag_bits   (i_flag_bits),
        .i_field_width (i_field_width),
        .i_precision   (i_precision),
        .o_strobe      (o_strobe),
        .o_out_char    (o_out_char),
        .o_last        (o_last),
        .o_total_count (o_total_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void format_field(input t_fmt_req r);
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] t;
        logic [7:0]  pre [0:2];
        logic [7:0]  dig [0:DIGIT_BUFFER-1];
        logic [7:0]  text [$];
        logic [2:0]  op;
        int          plen, len, prec, w, n, i;
        bit          left, zpad, plus, space, alt, sgn, cap, octpre, hexpre;
        t_fmt_char   c;
        op     = (r.opcode > OP_PTR) ? OP_UDEC : r.opcode;
        left   = r.flags[FLAG_LEFT];
        zpad   = r.flags[FLAG_ZPAD];
        plus   = r.flags[FLAG_PLUS];
        space  = r.flags[FLAG_SPACE];
        alt    = r.flags[FLAG_ALT];
        sgn    = 1'b0;
        cap    = 1'b0;
        octpre = 1'b0;
        hexpre = 1'b0;
        base   = 32'd10;
        case (op)
            OP_SDEC: sgn = 1'b1;
            OP_OCT: begin
                base   = 32'd8;
                octpre = alt;
            end
            OP_LHEX: begin
                base   = 32'd16;
                hexpre = alt;
            end
            OP_UHEX: begin
                base   = 32'd16;
                hexpre = alt;
                cap    = 1'b1;
            end
            OP_PTR: begin
                base   = 32'd16;
                hexpre = 1'b1;
            end
            default: ;
        endcase
        prec = r.prec[6] ? -1 : int'(r.prec[5:0]);
        if (prec > TB_MAX_FIELD - 2) prec = TB_MAX_FIELD - 2;
        w = (int'(r.width) > TB_MAX_FIELD) ? TB_MAX_FIELD : int'(r.width);
        if (left) zpad = 1'b0;
        if (plus) space = 1'b0;
        if (prec >= 0) zpad = 1'b0;
        plen = 0;
        mag  = r.value;
        if (sgn) begin
            if (r.value[31]) begin
                mag = -r.value;
                pre[plen] = CH_MINUS;
                plen++;
            end else if (plus) begin
                pre[plen] = CH_PLUS;
                plen++;
            end else if (space) begin
                pre[plen] = CH_SPACE;
                plen++;
            end
        end
        if (r.value != 0 && hexpre) begin
            pre[plen]     = CH_ZERO;
            pre[plen + 1] = cap ? CH_UX : CH_LX;
            plen += 2;
        end
        len = 0;
        while (mag != 0 && len < DIGIT_BUFFER) begin
            t = mag % base;
            if (t < 10) dig[len] = CH_ZERO + t[7:0];
            else dig[len] = (cap ? CH_UA : CH_LA) + t[7:0] - 8'd10;
            len++;
            mag = mag / base;
        end
        if ((r.value == 0 || octpre) && len < DIGIT_BUFFER) begin
            dig[len] = CH_ZERO;
            len++;
        end
        n = ((len > prec) ? len : prec) + plen;
        if (!left && !zpad) for (i = 0; i < w - n; i++) text.push_back(CH_SPACE);
        for (i = 0; i < plen; i++) text.push_back(pre[i]);
        if (zpad) for (i = 0; i < w - n; i++) text.push_back(CH_ZERO);
        for (i = 0; i < prec - len; i++) text.push_back(CH_ZERO);
        for (i = len - 1; i >= 0; i--) text.push_back(dig[i]);
        if (left) for (i = 0; i < w - n; i++) text.push_back(CH_SPACE);
        while (text.size() > TB_MAX_FIELD) void'(text.pop_back());
        for (i = 0; i < text.size(); i++) begin
            c.ch    = text[i];
            c.last  = (i == text.size() - 1);
            c.count = c.last ? 7'(text.size()) : 7'd0;
            field_chars.push_back(c);
        end
    endfunction

    function automatic logic [7:0] pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 8'd0;
        else if (r < 16) return 8'($urandom_range(1, 8));
        else if (r < 19) return 8'($urandom_range(9, 60));
        else return 8'($urandom_range(61, 150));
    endfunction

    task automatic add_req(input logic [31:0] value, input logic [2:0] op,
                           input logic [4:0] flags, input logic [6:0] width,
                           input logic [6:0] prec, input logic drain);
        t_fmt_req r;
        r.value  = value;
        r.opcode = op;
        r.flags  = flags;
        r.width  = width;
        r.prec   = prec;
        r.gap    = pick_gap();
        r.drain  = drain;
        format_reqs.push_back(r);
    endtask

    always @(posedge i_clk) begin : drive
        logic next_start;
        next_start = start;
        if (!i_rst_n) begin
            next_start  = 1'b0;
            idle_cycles = 0;
        end else begin
            if (start && !busy) begin
                format_field(cur_req);
                accepted_count <= accepted_count + 1;
                next_start  = 1'b0;
                idle_cycles = 0;
            end
            if (!next_start && format_reqs.size() != 0) begin
                if (idle_cycles < int'(format_reqs[0].gap)) begin
                    idle_cycles++;
                end else if (!format_reqs[0].drain || (field_chars.size() == 0 && !busy)) begin
                    cur_req = format_reqs.pop_front();
                    i_value       <= cur_req.value;
                    i_opcode      <= cur_req.opcode;
                    i_flag_bits   <= cur_req.flags;
                    i_field_width <= cur_req.width;
                    i_precision   <= cur_req.prec;
                    next_start = 1'b1;
                end
            end
        end
        start <= next_start;
    end

    always @(posedge i_clk) begin : check
        t_fmt_char want;
        if (i_rst_n && o_strobe) begin
            if (field_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("stray character %h last %b count %0d with nothing pending",
                             o_out_char, o_last, o_total_count);
            end else begin
                want = field_chars.pop_front();
                chars_checked++;
                if (o_out_char !== want.ch || o_last !== want.last ||
                    o_total_count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("char %0d: want %h last %b count %0d, got %h last %b count %0d",
                                 chars_checked, want.ch, want.last, want.count,
                                 o_out_char, o_last, o_total_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] value;
        logic [2:0]  op;
        logic [6:0]  width;
        logic [6:0]  prec;
        int          i, r, burst;
        add_req(32'd0,          OP_SDEC, 5'b00000, 7'd0,   7'h7f, 1'b0);
        add_req(32'd0,          OP_SDEC, 5'b00000, 7'd0,   7'd0,  1'b0);
        add_req(32'h8000_0000,  OP_SDEC, 5'b00000, 7'd0,   7'h7f, 1'b0);
        add_req(32'h7fff_ffff,  OP_SDEC, 5'b00100, 7'd20,  7'h7f, 1'b0);
        add_req(32'd5,          OP_SDEC, 5'b01000, 7'd0,   7'h7f, 1'b0);
        add_req(32'd5,          OP_SDEC, 5'b01100, 7'd4,   7'h7f, 1'b0);
        add_req(-32'd42,        OP_SDEC, 5'b00010, 7'd10,  7'h7f, 1'b0);
        add_req(-32'd42,        OP_SDEC, 5'b00011, 7'd10,  7'h7f, 1'b0);
        add_req(32'd42,         OP_SDEC, 5'b00010, 7'd10,  7'd5,  1'b0);
        add_req(32'hffff_ffff,  OP_UDEC, 5'b00000, 7'd0,   7'h7f, 1'b0);
        add_req(32'd8,          OP_OCT,  5'b10000, 7'd0,   7'h7f, 1'b0);
        add_req(32'd0,          OP_OCT,  5'b10000, 7'd3,   7'h7f, 1'b0);
        add_req(32'hdead_beef,  OP_LHEX, 5'b10010, 7'd12,  7'h7f, 1'b1);
        add_req(32'h00ab_cdef,  OP_UHEX, 5'b10001, 7'd15,  7'h7f, 1'b0);
        add_req(32'd0,          OP_LHEX, 5'b10000, 7'd0,   7'h7f, 1'b0);
        add_req(32'd0,          OP_PTR,  5'b00000, 7'd0,   7'h7f, 1'b0);
        add_req(32'h0000_1234,  OP_PTR,  5'b00000, 7'd0,   7'h7f, 1'b0);
        add_req(32'd123,        3'd6,    5'b01100, 7'd5,   7'h7f, 1'b0);
        add_req(32'hffff_ffff,  3'd7,    5'b10000, 7'd0,   7'd3,  1'b0);
        add_req(32'd1,          OP_SDEC, 5'b00010, 7'd127, 7'h7f, 1'b0);
        add_req(32'hffff_ffff,  OP_PTR,  5'b00000, 7'd0,   7'd63, 1'b0);
        add_req(32'd77,         OP_SDEC, 5'b00000, 7'd6,   7'h40, 1'b0);
        add_req(32'hffff_ffff,  OP_OCT,  5'b10001, 7'd64,  7'h7e, 1'b0);
        add_req(32'hffff_ffff,  OP_SDEC, 5'b11111, 7'd64,  7'd62, 1'b0);
        add_req(32'h0000_000f,  OP_LHEX, 5'b00000, 7'd0,   7'd0,  1'b0);
        burst = 0;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                0: value = 32'd0;
                1: value = $urandom_range(0, 20);
                2: value = -32'($urandom_range(1, 20));
                3: value = 32'h8000_0000 ^ 32'($urandom_range(0, 3));
                4: value = 32'd1 << $urandom_range(0, 31);
                5: value = (32'd1 << $urandom_range(0, 31)) - 32'd1;
                default: value = $urandom;
            endcase
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            r = $urandom_range(0, 19);
            if (r < 14) width = 7'($urandom_range(0, 16));
            else if (r < 18) width = 7'($urandom_range(17, 64));
            else width = 7'($urandom_range(65, 127));
            r = $urandom_range(0, 19);
            if (r < 6) prec = 7'h40 | 7'($urandom_range(0, 63));
            else if (r < 16) prec = 7'($urandom_range(0, 12));
            else if (r < 19) prec = 7'($urandom_range(13, 40));
            else prec = 7'($urandom_range(41, 63));
            add_req(value, op, 5'($urandom_range(0, 31)), width, prec, (i % 50) == 49);
            if (burst > 0) begin
                format_reqs[format_reqs.size() - 1].gap = 8'd0;
                burst--;
            end else if ($urandom_range(0, 39) == 0) begin
                burst = $urandom_range(10, 25);
            end
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (format_reqs.size() != 0 || start || field_chars.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d conversions over all kinds, flags, saturating widths and precisions",
                 accepted_count);
        $display("%0d characters compared, %0d mismatches", chars_checked, mismatch_count);
        if (mismatch_count == 0 && field_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/itf_pkg.sv
hw/rtl/itf_digits.sv
hw/rtl/integer_text_formatter_top.sv
hw/rtl/itf_checker.sv
sim/tb_top.sv
